// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dll_pkg.sv =====
package dll_pkg;

   // request selectors
   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_LEFT    = 3'd1;
   localparam logic [2:0] OP_RIGHT   = 3'd2;
   localparam logic [2:0] OP_SWAP    = 3'd3;
   localparam logic [2:0] OP_REVERSE = 3'd4;
   localparam logic [2:0] OP_SUM     = 3'd5;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      NX_SEQ,     // step + 1
      NX_UNTIL,   // repeat until counter reaches n
      NX_MOVE     // dispatch on move kind
   } nx_type;

   typedef enum logic [3:0] {
      SEL_ZERO,
      SEL_J,
      SEL_JINC,
      SEL_X,
      SEL_Y,
      SEL_LX,
      SEL_RX,
      SEL_LY,
      SEL_RY
   } sel_type;

   typedef enum logic [1:0] {
      RA_NONE,
      RA_Y,
      RA_CHAIN
   } raddr_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_X,
      CAP_Y,
      CAP_SUM
   } cap_type;

   typedef enum logic [4:0] {
      U_END      = 5'd0,
      U_INIT     = 5'd1,
      U_INIT_END = 5'd2,
      U_SUM      = 5'd3,
      U_SUM_END  = 5'd4,
      U_MV_A     = 5'd5,
      U_MV_B     = 5'd6,
      U_L_0      = 5'd7,
      U_L_1      = 5'd8,
      U_L_2      = 5'd9,
      U_R_0      = 5'd10,
      U_R_1      = 5'd11,
      U_R_2      = 5'd12,
      U_SA_0     = 5'd13,
      U_SA_1     = 5'd14,
      U_SA_2     = 5'd15,
      U_SG_0     = 5'd16,
      U_SG_1     = 5'd17,
      U_SG_2     = 5'd18,
      U_SG_3     = 5'd19
   } upc_type;

   typedef struct packed {
      nx_type    nx;
      logic      last;
      logic      wr;       // join(a, b): next[a] = b, prev[b] = a
      sel_type   a_sel;
      sel_type   b_sel;
      raddr_type ra;
      cap_type   cap;
      logic      cnt_inc;
   } ctrl_word_type;

   function automatic ctrl_word_type cw_join(sel_type a, sel_type b, logic last);
      ctrl_word_type cw;
      cw = '0;
      cw.nx    = NX_SEQ;
      cw.wr    = 1'b1;
      cw.a_sel = a;
      cw.b_sel = b;
      cw.last  = last;
      return cw;
   endfunction

   // microprogram ROM
   function automatic ctrl_word_type ucode(upc_type upc);
      ctrl_word_type cw;
      cw = '0;
      cw.nx = NX_SEQ;
      unique case (upc)
         U_END:      cw.last = 1'b1;
         U_INIT: begin
            cw.nx      = NX_UNTIL;
            cw.wr      = 1'b1;
            cw.a_sel   = SEL_J;
            cw.b_sel   = SEL_JINC;
            cw.cnt_inc = 1'b1;
         end
         U_INIT_END: cw = cw_join(SEL_J, SEL_ZERO, 1'b1);
         U_SUM: begin
            cw.nx      = NX_UNTIL;
            cw.ra      = RA_CHAIN;
            cw.cap     = CAP_SUM;
            cw.cnt_inc = 1'b1;
         end
         U_SUM_END:  cw.last = 1'b1;
         U_MV_A: begin
            cw.ra  = RA_Y;
            cw.cap = CAP_X;
         end
         U_MV_B: begin
            cw.nx  = NX_MOVE;
            cw.cap = CAP_Y;
         end
         U_L_0:      cw = cw_join(SEL_LX, SEL_RX, 1'b0);
         U_L_1:      cw = cw_join(SEL_LY, SEL_X,  1'b0);
         U_L_2:      cw = cw_join(SEL_X,  SEL_Y,  1'b1);
         U_R_0:      cw = cw_join(SEL_LX, SEL_RX, 1'b0);
         U_R_1:      cw = cw_join(SEL_Y,  SEL_X,  1'b0);
         U_R_2:      cw = cw_join(SEL_X,  SEL_RY, 1'b1);
         U_SA_0:     cw = cw_join(SEL_LX, SEL_Y,  1'b0);
         U_SA_1:     cw = cw_join(SEL_Y,  SEL_X,  1'b0);
         U_SA_2:     cw = cw_join(SEL_X,  SEL_RY, 1'b1);
         U_SG_0:     cw = cw_join(SEL_LX, SEL_Y,  1'b0);
         U_SG_1:     cw = cw_join(SEL_Y,  SEL_RX, 1'b0);
         U_SG_2:     cw = cw_join(SEL_LY, SEL_X,  1'b0);
         U_SG_3:     cw = cw_join(SEL_X,  SEL_RY, 1'b1);
         default:    cw.last = 1'b1;
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/doubly_linked_order_list.sv =====
// Channel   Dir  Handshake            Payload
// req_      in   req_tvalid/tready    tdata: first_box, second_box; tuser: operation
// rsp_      out  rsp_tvalid/tready    tdata: odd_position_sum; tuser: skipped, error
// csr_      in   csr_wr_en            csr_wr_data: box_count
//
// Each microprogram step does at most one join (one write per table) or one table read;
// init and sum walk the n entries one per cycle. The next request can be taken in the
// cycle after the result loads. Synchronous reset clears control state only.
// A result not yet taken holds the sequencer on its final step until rsp_tready.
`include "assert_macros.svh"

module doubly_linked_order_list
   import dll_pkg::*;
#(
   parameter int MAX_BOXES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [10:0] first_box, [21:11] second_box
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] odd_position_sum
   output logic [1:0]  rsp_tuser,   // [0] skipped, [1] error
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data  // box_count
);

   localparam int IDX_W = $clog2(MAX_BOXES + 1);
   localparam int CMP_W = (IDX_W > 11) ? IDX_W : 11;
   localparam int DEPTH = MAX_BOXES + 1;

   typedef logic [IDX_W-1:0] idx_type;

   // link tables
   idx_type next_mem [DEPTH];
   idx_type prev_mem [DEPTH];

   seq_state_type state_ff, state_in;
   upc_type       upc_ff, upc_in;
   logic [10:0]   csr_count_ff;
   idx_type       n_ff, n_in;
   logic          list_ready_ff, list_ready_in;
   logic          reversed_ff, reversed_in;
   logic [2:0]    kind_ff, kind_in;
   idx_type       x_ff, x_in, y_ff, y_in;
   idx_type       lx_ff, lx_in, rx_ff, rx_in, ly_ff, ly_in, ry_ff, ry_in;
   idx_type       j_ff, j_in;
   logic [19:0]   sum_ff, sum_in, tri_ff, tri_in;
   logic          skip_ff, skip_in, err_ff, err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [19:0]   rsp_sum_ff;
   logic          rsp_skip_ff, rsp_err_ff;
   idx_type       rd_next_ff, rd_prev_ff;

   ctrl_word_type cw;
   logic          accept, running, step_go, load_rsp, cnt_hit;
   idx_type       j_inc;
   logic [2:0]    req_op;
   logic [10:0]   req_x, req_y;
   logic [CMP_W-1:0] x_c, y_c, n_c, bc_c;
   logic          is_move, ids_bad, req_err;
   logic [2:0]    eff_op;
   idx_type       clamp_n;
   upc_type       entry_upc, move_upc;
   logic          swap_flip, mv_skip, swap_adj;
   logic          rd_en, wr_en;
   idx_type       rd_addr, wr_a, wr_b;
   logic [19:0]   final_sum;

   assign req_op = req_tuser[2:0];
   assign req_x  = req_tdata[10:0];
   assign req_y  = req_tdata[21:11];

   assign cw      = ucode(upc_ff);
   assign accept  = req_tvalid && req_tready;
   assign running = (state_ff == SEQ_RUN);
   assign step_go = running && !(cw.last && rsp_valid_ff && !rsp_tready);
   assign load_rsp = step_go && cw.last;
   assign j_inc   = j_ff + 1'b1;
   assign cnt_hit = (j_inc == n_ff);

   // request checks
   assign x_c  = CMP_W'(req_x);
   assign y_c  = CMP_W'(req_y);
   assign n_c  = CMP_W'(n_ff);
   assign bc_c = CMP_W'(csr_count_ff);
   assign is_move = (req_op == OP_LEFT) || (req_op == OP_RIGHT) || (req_op == OP_SWAP);
   assign ids_bad = (x_c == '0) || (x_c > n_c) || (y_c == '0) || (y_c > n_c) ||
                    (x_c == y_c);
   assign req_err = (req_op != OP_INIT) &&
                    ((req_op > OP_SUM) || !list_ready_ff || (is_move && ids_bad));

   always_comb begin
      if (bc_c == '0) begin
         clamp_n = IDX_W'(1);
      end else if (bc_c > CMP_W'(MAX_BOXES)) begin
         clamp_n = IDX_W'(MAX_BOXES);
      end else begin
         clamp_n = IDX_W'(bc_c);
      end
   end

   // mirror left/right while reversed
   always_comb begin
      eff_op = req_op;
      if (reversed_ff && (req_op == OP_LEFT)) eff_op = OP_RIGHT;
      if (reversed_ff && (req_op == OP_RIGHT)) eff_op = OP_LEFT;
   end

   always_comb begin
      priority if (req_op == OP_INIT) begin
         entry_upc = U_INIT;
      end else if (req_err) begin
         entry_upc = U_END;
      end else if (req_op == OP_SUM) begin
         entry_upc = U_SUM;
      end else if (is_move) begin
         entry_upc = U_MV_A;
      end else begin
         entry_upc = U_END;
      end
   end

   // rd_*_ff hold prev[y]/next[y] during the second move step
   assign swap_flip = (kind_ff == OP_SWAP) && (rd_next_ff == x_ff);
   assign mv_skip   = ((kind_ff == OP_LEFT) && (rd_prev_ff == x_ff)) ||
                      ((kind_ff == OP_RIGHT) && (rd_next_ff == x_ff));
   assign swap_adj  = (rd_next_ff == x_ff) || (rx_ff == y_ff);

   always_comb begin
      priority if (mv_skip) begin
         move_upc = U_END;
      end else if (kind_ff == OP_LEFT) begin
         move_upc = U_L_0;
      end else if (kind_ff == OP_RIGHT) begin
         move_upc = U_R_0;
      end else if (swap_adj) begin
         move_upc = U_SA_0;
      end else begin
         move_upc = U_SG_0;
      end
   end

   // sequencer state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (accept) state_in = SEQ_RUN;
         SEQ_RUN:  if (load_rsp) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == SEQ_IDLE);
   end

   always_comb begin
      upc_in = upc_ff;
      if (accept) begin
         upc_in = entry_upc;
      end else if (step_go && !cw.last) begin
         unique case (cw.nx)
            NX_SEQ:   upc_in = upc_type'(upc_ff + 5'd1);
            NX_UNTIL: if (cnt_hit) upc_in = upc_type'(upc_ff + 5'd1);
            NX_MOVE:  upc_in = move_upc;
            default:  upc_in = U_END;
         endcase
      end
   end

   // join operands
   always_comb begin
      unique case (cw.a_sel)
         SEL_ZERO: wr_a = '0;
         SEL_J:    wr_a = j_ff;
         SEL_JINC: wr_a = j_inc;
         SEL_X:    wr_a = x_ff;
         SEL_Y:    wr_a = y_ff;
         SEL_LX:   wr_a = lx_ff;
         SEL_RX:   wr_a = rx_ff;
         SEL_LY:   wr_a = ly_ff;
         SEL_RY:   wr_a = ry_ff;
         default:  wr_a = '0;
      endcase
   end

   always_comb begin
      unique case (cw.b_sel)
         SEL_ZERO: wr_b = '0;
         SEL_J:    wr_b = j_ff;
         SEL_JINC: wr_b = j_inc;
         SEL_X:    wr_b = x_ff;
         SEL_Y:    wr_b = y_ff;
         SEL_LX:   wr_b = lx_ff;
         SEL_RX:   wr_b = rx_ff;
         SEL_LY:   wr_b = ly_ff;
         SEL_RY:   wr_b = ry_ff;
         default:  wr_b = '0;
      endcase
   end

   assign wr_en = step_go && cw.wr;

   // read port: x at transfer (sentinel for sum), y or chain later
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (accept) begin
         rd_en   = 1'b1;
         rd_addr = (req_op == OP_SUM) ? '0 : IDX_W'(req_x);
      end else if (step_go && (cw.ra == RA_Y)) begin
         rd_en   = 1'b1;
         rd_addr = y_ff;
      end else if (step_go && (cw.ra == RA_CHAIN)) begin
         rd_en   = 1'b1;
         rd_addr = rd_next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         next_mem[wr_a] <= wr_b;
         prev_mem[wr_b] <= wr_a;
      end
      if (rd_en) begin
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   // datapath
   always_comb begin
      n_in          = n_ff;
      list_ready_in = list_ready_ff;
      reversed_in   = reversed_ff;
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      lx_in         = lx_ff;
      rx_in         = rx_ff;
      ly_in         = ly_ff;
      ry_in         = ry_ff;
      j_in          = j_ff;
      sum_in        = sum_ff;
      tri_in        = tri_ff;
      skip_in       = skip_ff;
      err_in        = err_ff;
      if (accept) begin
         kind_in = eff_op;
         x_in    = IDX_W'(req_x);
         y_in    = IDX_W'(req_y);
         j_in    = '0;
         sum_in  = '0;
         tri_in  = '0;
         skip_in = 1'b0;
         err_in  = req_err;
         if (req_op == OP_INIT) begin
            n_in          = clamp_n;
            list_ready_in = 1'b1;
            reversed_in   = 1'b0;
         end
         if ((req_op == OP_REVERSE) && !req_err) reversed_in = !reversed_ff;
      end else if (step_go) begin
         if (cw.cnt_inc) j_in = j_inc;
         unique case (cw.cap)
            CAP_NONE: ;
            CAP_X: begin
               lx_in = rd_prev_ff;
               rx_in = rd_next_ff;
            end
            CAP_Y: begin
               skip_in = mv_skip;
               if (swap_flip) begin
                  // next[y] == x: exchange roles so x is left of y
                  x_in  = y_ff;
                  y_in  = x_ff;
                  lx_in = rd_prev_ff;
                  rx_in = rd_next_ff;
                  ly_in = lx_ff;
                  ry_in = rx_ff;
               end else begin
                  ly_in = rd_prev_ff;
                  ry_in = rd_next_ff;
               end
            end
            CAP_SUM: begin
               // j counts from 0, so even j is an odd position
               if (!j_ff[0]) sum_in = sum_ff + 20'(rd_next_ff);
               tri_in = tri_ff + 20'(j_inc);
            end
            default: ;
         endcase
      end
   end

   assign final_sum = (reversed_ff && !n_ff[0]) ? (tri_ff - sum_ff) : sum_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         upc_ff        <= U_END;
         csr_count_ff  <= 11'd1;
         n_ff          <= IDX_W'(1);
         list_ready_ff <= 1'b0;
         reversed_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         upc_ff        <= upc_in;
         if (csr_wr_en) csr_count_ff <= csr_wr_data;
         n_ff          <= n_in;
         list_ready_ff <= list_ready_in;
         reversed_ff   <= reversed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      lx_ff   <= lx_in;
      rx_ff   <= rx_in;
      ly_ff   <= ly_in;
      ry_ff   <= ry_in;
      j_ff    <= j_in;
      sum_ff  <= sum_in;
      tri_ff  <= tri_in;
      skip_ff <= skip_in;
      err_ff  <= err_in;
      if (load_rsp) begin
         rsp_sum_ff  <= final_sum;
         rsp_skip_ff <= skip_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_sum_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_skip_ff};

   `CHK_IMPLY(a_no_overwrite, clock, reset, load_rsp, !rsp_valid_ff || rsp_tready)
   `CHK_IMPLY(a_flags_exclusive, clock, reset, rsp_valid_ff, !(rsp_skip_ff && rsp_err_ff))
   `CHK_NEXT(a_init_sets_ready, clock, reset, accept && (req_op == OP_INIT), list_ready_ff && !reversed_ff && (n_ff != '0))
   `CHK_IMPLY(a_count_bound, clock, reset, running, j_ff <= n_ff)

endmodule

// ===== tb/doubly_linked_order_list_tb.sv =====
`timescale 1ns / 1ps

module doubly_linked_order_list_tb
   import dll_pkg::*;
();

   localparam int MAX_BOXES      = 1024;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 175;
   localparam int DIRECTED_ROWS  = 27;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_LIMIT    = 20;
   // worst case: every request an n=1024 walk plus long stalls, with margin
   localparam int CYCLE_LIMIT    = 8_000_000;

   // selectors the block has no operation for
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [19:0] odd_sum;
      logic        skipped;
      logic        error;
   } box_result_type;

   typedef struct packed {
      logic [2:0]     op;
      logic [10:0]    first_box;
      logic [10:0]    second_box;
      logic           fixed;      // want typed in below, else taken from the predictor
      box_result_type want;
   } directed_row_type;

   localparam box_result_type R_OK   = '{20'd0, 1'b0, 1'b0};
   localparam box_result_type R_SKIP = '{20'd0, 1'b1, 1'b0};
   localparam box_result_type R_ERR  = '{20'd0, 1'b0, 1'b1};

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [2:0]  req_tuser   = OP_INIT;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [10:0] csr_wr_data = '0;

   // predictor state
   logic [10:0] link_prev [0:MAX_BOXES];
   logic [10:0] link_next [0:MAX_BOXES];
   logic        flag_reversed = 1'b0;
   logic        list_built    = 1'b0;
   logic [10:0] count_reg     = 11'd1;
   int unsigned live_n        = 1;

   box_result_type expected_q [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fail_count    = 0;
   int result_count  = 0;
   int sent_count    = 0;
   int sum_count     = 0;
   int skip_count    = 0;
   int reject_count  = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;

   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // nothing is allowed before the first init
      '{OP_LEFT,      11'd1,    11'd2,    1'b1, R_ERR},
      '{OP_SWAP,      11'd1,    11'd2,    1'b1, R_ERR},
      '{OP_REVERSE,   11'd0,    11'd0,    1'b1, R_ERR},
      '{OP_SUM,       11'd0,    11'd0,    1'b1, R_ERR},
      '{OP_UNUSED_LO, 11'd0,    11'd0,    1'b1, R_ERR},
      '{OP_UNUSED_HI, 11'd2047, 11'd2047, 1'b1, R_ERR},
      // n = 4: identity order 1 2 3 4
      '{OP_INIT,      11'd2047, 11'd2047, 1'b1, R_OK},
      '{OP_SUM,       11'd5,    11'd9,    1'b1, '{20'd4, 1'b0, 1'b0}},
      '{OP_REVERSE,   11'd0,    11'd0,    1'b1, R_OK},
      '{OP_SUM,       11'd0,    11'd0,    1'b1, '{20'd6, 1'b0, 1'b0}},
      '{OP_REVERSE,   11'd0,    11'd0,    1'b1, R_OK},
      '{OP_LEFT,      11'd1,    11'd2,    1'b1, R_SKIP},
      '{OP_RIGHT,     11'd2,    11'd1,    1'b1, R_SKIP},
      '{OP_LEFT,      11'd0,    11'd1,    1'b1, R_ERR},
      '{OP_RIGHT,     11'd1,    11'd5,    1'b1, R_ERR},
      '{OP_SWAP,      11'd3,    11'd3,    1'b1, R_ERR},
      '{OP_LEFT,      11'd2047, 11'd1024, 1'b1, R_ERR},
      '{OP_LEFT,      11'd4,    11'd1,    1'b0, R_OK},
      '{OP_RIGHT,     11'd1,    11'd3,    1'b0, R_OK},
      '{OP_SWAP,      11'd2,    11'd4,    1'b0, R_OK},
      '{OP_SWAP,      11'd1,    11'd3,    1'b0, R_OK},
      '{OP_REVERSE,   11'd0,    11'd0,    1'b1, R_OK},
      '{OP_RIGHT,     11'd2,    11'd3,    1'b0, R_OK},
      '{OP_SUM,       11'd0,    11'd0,    1'b0, R_OK},
      '{OP_SWAP,      11'd4,    11'd2,    1'b0, R_OK},
      '{OP_UNUSED_LO, 11'd1,    11'd2,    1'b1, R_ERR},
      '{OP_INIT,      11'd0,    11'd0,    1'b1, R_OK}
   };

   // box counts per random phase; 0 and 2047 land on the clamp limits
   logic [10:0] phase_counts [0:PHASE_COUNT-1] = '{
      11'd2047, 11'd3, 11'd1, 11'd8, 11'd17, 11'd1024, 11'd2, 11'd0, 11'd100, 11'd5
   };
   int send_modes  [0:3] = '{0, 63, 0, 11};
   int stall_modes [0:3] = '{0, 0, 63, 11};

   doubly_linked_order_list #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void link_pair(int unsigned a, int unsigned b);
      link_next[a] = b[10:0];
      link_prev[b] = a[10:0];
   endfunction

   // applies one request to the predicted list and returns its result
   function automatic box_result_type model_request(logic [2:0] op_in, logic [10:0] x_in,
                                                    logic [10:0] y_in);
      box_result_type res;
      logic [2:0]  op;
      int unsigned n, x, y, t, acc, b, lx, rx, ly, ry;
      res = R_OK;
      op  = op_in;
      x   = x_in;
      y   = y_in;
      n   = live_n;
      acc = 0;
      if (op == OP_INIT) begin
         n = (count_reg == 0) ? 1 : ((count_reg > MAX_BOXES) ? MAX_BOXES : count_reg);
         live_n = n;
         for (int unsigned i = 1; i < n; i++) begin
            link_prev[i] = 11'(i - 1);
            link_next[i] = 11'(i + 1);
         end
         link_prev[0] = 11'(n);
         link_prev[n] = 11'(n - 1);
         link_next[0] = 11'd1;
         link_next[n] = 11'd0;
         flag_reversed = 1'b0;
         list_built    = 1'b1;
      end else if (op > OP_SUM || !list_built) begin
         res.error = 1'b1;
      end else if (op == OP_REVERSE) begin
         flag_reversed = ~flag_reversed;
      end else if (op == OP_SUM) begin
         b = 0;
         for (int unsigned pos = 1; pos <= n; pos++) begin
            b = link_next[b];
            if (pos[0]) acc += b;
         end
         // reversed list of even length: odd positions hold the complement
         if (flag_reversed && !n[0]) acc = n * (n + 1) / 2 - acc;
         res.odd_sum = acc[19:0];
      end else if (x < 1 || x > n || y < 1 || y > n || x == y) begin
         res.error = 1'b1;
      end else begin
         if (op == OP_SWAP && link_next[y] == x) begin
            t = x;
            x = y;
            y = t;
         end
         if (op != OP_SWAP && flag_reversed) op = (op == OP_LEFT) ? OP_RIGHT : OP_LEFT;
         if (op == OP_LEFT && link_prev[y] == x) begin
            res.skipped = 1'b1;
         end else if (op == OP_RIGHT && link_next[y] == x) begin
            res.skipped = 1'b1;
         end else begin
            lx = link_prev[x];
            rx = link_next[x];
            ly = link_prev[y];
            ry = link_next[y];
            if (op == OP_LEFT) begin
               link_pair(lx, rx);
               link_pair(ly, x);
               link_pair(x, y);
            end else if (op == OP_RIGHT) begin
               link_pair(lx, rx);
               link_pair(y, x);
               link_pair(x, ry);
            end else if (rx == y) begin
               link_pair(lx, y);
               link_pair(y, x);
               link_pair(x, ry);
            end else begin
               link_pair(lx, y);
               link_pair(y, rx);
               link_pair(ly, x);
               link_pair(x, ry);
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
                  result_count, what, want, got);
   endtask

   task automatic write_box_count(logic [10:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_reg = value;
      csr_writes++;
   endtask

   task automatic send_request(logic [2:0] op, logic [10:0] first, logic [10:0] second,
                               logic fixed, box_result_type fixed_want);
      box_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, second, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = model_request(op, first, second);
      expected_q.push_back(fixed ? fixed_want : predicted);
      sent_count++;
      if (op == OP_SUM && !predicted.error) sum_count++;
      if (predicted.skipped) skip_count++;
      if (predicted.error) reject_count++;
   endtask

   // mostly legal moves and swaps, biased toward neighbors so skips and
   // adjacent swaps come up often; the rest is init, reverse, sum or noise
   task automatic send_random(int unsigned n);
      int unsigned pick, x, y;
      logic [2:0]  op;
      pick = $urandom_range(0, 99);
      op   = OP_REVERSE;
      x    = $urandom_range(0, 2047);
      y    = $urandom_range(0, 2047);
      if (pick < 3) begin
         op = OP_INIT;
      end else if (pick < 8) begin
         op = OP_REVERSE;
      end else if (pick < 13) begin
         op = OP_SUM;
      end else if (pick < 82 && n > 1) begin
         op = 3'($urandom_range(OP_LEFT, OP_SWAP));
         x  = $urandom_range(1, n);
         case ($urandom_range(0, 3))
            0: y = link_next[x];
            1: y = link_prev[x];
            default: y = $urandom_range(1, n);
         endcase
         if (y == 0 || y == x) y = (x % n) + 1;
      end else if (pick < 94) begin
         op = 3'($urandom_range(OP_LEFT, OP_SWAP));
         if (pick[0]) y = x;
      end else begin
         op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      send_request(op, x[10:0], y[10:0], 1'b0, R_OK);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      box_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending, sum", 0, rsp_tdata[19:0]);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[19:0] !== want.odd_sum)
               report_mismatch("odd_position_sum", want.odd_sum, rsp_tdata[19:0]);
            if (rsp_tuser[0] !== want.skipped)
               report_mismatch("skipped", want.skipped, rsp_tuser[0]);
            if (rsp_tuser[1] !== want.error)
               report_mismatch("error", want.error, rsp_tuser[1]);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_box_count(11'd4);

      send_idle_pct = 11;
      stall_pct     = 11;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].op, directed_rows[i].first_box,
                      directed_rows[i].second_box, directed_rows[i].fixed,
                      directed_rows[i].want);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_box_count(phase_counts[p]);
         send_idle_pct = send_modes[p % 4];
         stall_pct     = stall_modes[p % 4];
         // new count only takes effect at init
         send_request(OP_INIT, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                      1'b0, R_OK);
         n = live_n;
         for (int k = 1; k < PHASE_ITEMS; k++) send_random(n);
         drain();
      end

      $display("Covered %0d requests over %0d box-count settings (n from 1 to %0d).",
               sent_count, csr_writes, MAX_BOXES);
      $display("%0d results checked: %0d sum queries, %0d skipped moves, %0d rejected.",
               result_count, sum_count, skip_count, reject_count);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
